/* design/sfp_pkg.sv */
// Shared types, constants and helpers for the settings frame parser.
// No dependencies; imported by sfp_varint and settings_frame_parser_top.
package sfp_pkg;

    localparam int VAL_W = 62;

    // Parser phase within one frame.
    typedef enum logic [2:0] {
        PH_TYPE,
        PH_LEN,
        PH_ID,
        PH_VALUE,
        PH_SKIP,
        PH_DONE
    } phase_t;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_PROTO   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FRAME_TYPE   = 2'd0;
    localparam logic [1:0] CFG_CONNECT_ID   = 2'd1;
    localparam logic [1:0] CFG_DATAGRAM_ID  = 2'd2;
    localparam logic [1:0] CFG_WT_ID        = 2'd3;

    // Configuration reset values.
    localparam logic [VAL_W-1:0] RST_FRAME_TYPE  = 62'd4;
    localparam logic [VAL_W-1:0] RST_CONNECT_ID  = 62'd8;
    localparam logic [VAL_W-1:0] RST_DATAGRAM_ID = 62'd51;
    localparam logic [VAL_W-1:0] RST_WT_ID       = 62'd727725890;

    localparam logic [7:0] VARINT_LOW_MASK = 8'h3f;

    // Status of the integer decoder for the byte being presented.
    typedef struct packed {
        logic starting;  // this byte opens a new integer
        logic done;      // the integer completes with this byte
    } varint_sts_t;

    // Encoded length in bytes of an integer whose first byte is b.
    function automatic logic [3:0] varint_len(input logic [7:0] b);
        logic [3:0] len;
        case (b[7:6])
            2'd0:    len = 4'd1;
            2'd1:    len = 4'd2;
            2'd2:    len = 4'd4;
            default: len = 4'd8;
        endcase
        return len;
    endfunction

endpackage

/* design/sfp_varint.sv */
// Variable-length integer accumulator: one byte per request, big-endian.
// Depends on sfp_pkg.
module sfp_varint import sfp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             feed,
    input  logic             clear,
    input  logic [7:0]       data_byte,
    output logic [VAL_W-1:0] acc_next,
    output varint_sts_t      sts
);

    logic [VAL_W-1:0] acc_reg;
    logic [2:0]       left_reg;
    logic [2:0]       left_next;
    logic [3:0]       len;

    always_comb begin
        len = varint_len(data_byte);
        if (left_reg == 3'd0) begin
            acc_next  = {{(VAL_W-8){1'b0}}, data_byte & VARINT_LOW_MASK};
            left_next = 3'(len - 4'd1);
        end else begin
            acc_next  = {acc_reg[VAL_W-9:0], data_byte};
            left_next = left_reg - 3'd1;
        end
        sts.starting = (left_reg == 3'd0);
        sts.done     = (left_next == 3'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= 3'd0;
        end else if (clear) begin
            left_reg <= 3'd0;
        end else if (feed) begin
            left_reg <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (feed) begin
            acc_reg <= acc_next;
        end
    end

endmodule

/* design/settings_frame_parser_top.sv */
// A result is valid in the cycle after its last-marked byte is accepted.
// Throughput: one byte per cycle while no result is left waiting; the whole parser state
// updates on each accepted byte through the integer accumulator and the payload counter.
// A result left waiting holds off the next byte until it is taken.
// Reset is synchronous, active low; it restores the configuration defaults
// and starts a new frame. Depends on sfp_pkg and sfp_varint.
module settings_frame_parser_top import sfp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,

    input  logic [7:0]       s_data_byte,
    input  logic             s_last,
    input  logic             s_valid,
    output logic             s_ready,

    output logic [1:0]       m_status,
    output logic             m_connect_enabled,
    output logic             m_datagram_enabled,
    output logic             m_webtransport_enabled,
    output logic             m_all_required,
    output logic             m_valid,
    input  logic             m_ready,

    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [VAL_W-1:0] cfg_data
);

    logic [VAL_W-1:0] cfg_type_reg, cfg_connect_reg, cfg_datagram_reg, cfg_wt_reg;

    phase_t           phase_reg, phase_next, ph_mid;
    logic [VAL_W-1:0] ftype_reg, ftype_next;
    logic [VAL_W-1:0] pay_reg, pay_next;
    logic [VAL_W-1:0] pend_reg, pend_next;
    logic [2:0]       flags_reg, flags_next;
    logic [1:0]       lstat_reg, lstat_next;

    logic [1:0]       res_status;
    logic [2:0]       res_flags;

    logic             m_valid_reg;
    logic [1:0]       m_status_reg;
    logic [2:0]       m_flags_reg;

    logic             s_accept;
    logic             feed_raw, clear_raw;
    logic [VAL_W-1:0] acc_next;
    varint_sts_t      vsts;
    logic             pay_short, pay_last, busy;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    sfp_varint u_varint (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .feed      (s_accept && feed_raw),
        .clear     (s_accept && clear_raw),
        .data_byte (s_data_byte),
        .acc_next  (acc_next),
        .sts       (vsts)
    );

    // The next integer does not fit in what is left of the payload.
    assign pay_short = (pay_reg[VAL_W-1:4] == '0) &&
                       (pay_reg[3:0] < varint_len(s_data_byte));
    // This byte is the final one of the payload.
    assign pay_last  = (pay_reg[VAL_W-1:1] == '0);

    always_comb begin
        phase_next = phase_reg;
        ph_mid     = phase_reg;
        ftype_next = ftype_reg;
        pay_next   = pay_reg;
        pend_next  = pend_reg;
        flags_next = flags_reg;
        lstat_next = lstat_reg;
        feed_raw   = 1'b0;
        clear_raw  = 1'b0;
        busy       = 1'b0;
        res_status = ST_OK;
        res_flags  = 3'd0;

        case (phase_reg)
            PH_TYPE: begin
                feed_raw = 1'b1;
                if (vsts.done) begin
                    ftype_next = acc_next;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN: begin
                feed_raw = 1'b1;
                if (vsts.done) begin
                    pay_next = acc_next;
                    if (ftype_reg != cfg_type_reg) begin
                        lstat_next = ST_PROTO;
                        phase_next = PH_DONE;
                    end else if (acc_next == '0) begin
                        lstat_next = ST_OK;
                        phase_next = PH_DONE;
                    end else begin
                        phase_next = PH_ID;
                    end
                end
            end
            PH_ID, PH_VALUE, PH_SKIP: begin
                if (phase_reg != PH_SKIP && vsts.starting && pay_short) begin
                    lstat_next = ST_INVALID;
                    ph_mid     = PH_SKIP;
                end
                if (pay_reg != '0) begin
                    pay_next = pay_reg - VAL_W'(1);
                end
                if (ph_mid == PH_ID || ph_mid == PH_VALUE) begin
                    feed_raw = 1'b1;
                    if (vsts.done) begin
                        if (ph_mid == PH_ID) begin
                            pend_next = acc_next;
                            ph_mid    = PH_VALUE;
                        end else begin
                            // First matching id wins; a zero value sets nothing.
                            if (acc_next != '0) begin
                                if (pend_reg == cfg_connect_reg) begin
                                    flags_next[0] = 1'b1;
                                end else if (pend_reg == cfg_datagram_reg) begin
                                    flags_next[1] = 1'b1;
                                end else if (pend_reg == cfg_wt_reg) begin
                                    flags_next[2] = 1'b1;
                                end
                            end
                            ph_mid = PH_ID;
                        end
                    end
                end
                busy = feed_raw ? !vsts.done : !vsts.starting;
                if (pay_last) begin
                    if (ph_mid == PH_SKIP || ph_mid == PH_VALUE || busy) begin
                        lstat_next = ST_INVALID;
                    end else begin
                        lstat_next = ST_OK;
                    end
                    clear_raw  = 1'b1;
                    phase_next = PH_DONE;
                end else begin
                    phase_next = ph_mid;
                end
            end
            default: ;
        endcase

        if (phase_next == PH_TYPE || phase_next == PH_LEN) begin
            res_status = ST_INVALID;
        end else if (phase_next == PH_DONE) begin
            res_status = lstat_next;
            res_flags  = (lstat_next == ST_PROTO) ? 3'd0 : flags_next;
        end else begin
            res_status = ST_PROTO;
        end

        // The final byte closes the frame; the next request starts a new one.
        if (s_last) begin
            phase_next = PH_TYPE;
            flags_next = 3'd0;
            lstat_next = ST_OK;
            clear_raw  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_type_reg     <= RST_FRAME_TYPE;
            cfg_connect_reg  <= RST_CONNECT_ID;
            cfg_datagram_reg <= RST_DATAGRAM_ID;
            cfg_wt_reg       <= RST_WT_ID;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FRAME_TYPE:  cfg_type_reg     <= cfg_data;
                CFG_CONNECT_ID:  cfg_connect_reg  <= cfg_data;
                CFG_DATAGRAM_ID: cfg_datagram_reg <= cfg_data;
                CFG_WT_ID:       cfg_wt_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TYPE;
            flags_reg <= 3'd0;
            lstat_reg <= ST_OK;
        end else if (s_accept) begin
            phase_reg <= phase_next;
            flags_reg <= flags_next;
            lstat_reg <= lstat_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            ftype_reg <= ftype_next;
            pay_reg   <= pay_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept && s_last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_last) begin
            m_status_reg <= res_status;
            m_flags_reg  <= res_flags;
        end
    end

    assign m_valid                = m_valid_reg;
    assign m_status               = m_status_reg;
    assign m_connect_enabled      = m_flags_reg[0];
    assign m_datagram_enabled     = m_flags_reg[1];
    assign m_webtransport_enabled = m_flags_reg[2];
    assign m_all_required         = &m_flags_reg;

`ifndef SYNTH
    a_result_follows_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last |=> m_valid)
        else $error("no result after the final byte of a frame");

    a_frame_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last |=> phase_reg == PH_TYPE && flags_reg == 3'd0)
        else $error("frame state not cleared after the final byte");

    a_proto_no_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_PROTO |-> m_flags_reg == 3'd0)
        else $error("flags reported with a protocol error");

    a_no_status_three: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != 2'd3)
        else $error("undefined status code in a result");

    a_done_header_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DONE |-> lstat_reg != 2'd3)
        else $error("undefined latched status after the payload");
`endif

endmodule
